// ===== hw/rtl/stsi_pkg.sv =====
// Shared types and constants for the sorted key table.
// No dependencies; every other file of the block refers to this package.
package stsi_pkg;

    localparam int DEPTH_DEFAULT     = 16;
    localparam int KEY_WIDTH_DEFAULT = 32;

    localparam int TYPE_W   = 2;
    localparam int KEY_IN_W = 32;
    localparam int POS_W    = 4;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 4;
    localparam int COUNT_W  = 5;

    typedef enum logic [TYPE_W-1:0] {
        REQ_INSERT = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_SEARCH = 2'd2
    } req_type_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_BADPOS   = 2'd3
    } status_t;

    // Command broadcast to every cell
    typedef struct packed {
        logic ins;
        logic del;
    } cell_ctrl_t;

    // Compare flags handed from a cell to its upper neighbour
    typedef struct packed {
        logic gt;
        logic eq;
    } link_t;

endpackage

// ===== hw/rtl/stsi_req_if.sv =====
// Request and response channel interfaces of the sorted key table.
// Depends on stsi_pkg for the field widths.
interface stsi_req_if;
    logic                              valid;
    logic                              ready;
    logic [stsi_pkg::TYPE_W-1:0]       req_type;
    logic [stsi_pkg::KEY_IN_W-1:0]     key;
    logic [stsi_pkg::POS_W-1:0]        position;

    modport source (output valid, req_type, key, position, input ready);
    modport sink   (input valid, req_type, key, position, output ready);
endinterface

interface stsi_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [stsi_pkg::STATUS_W-1:0]     status;
    logic [stsi_pkg::INDEX_W-1:0]      index;
    logic [stsi_pkg::COUNT_W-1:0]      count;

    modport source (output valid, status, index, count, input ready);
    modport sink   (input valid, status, index, count, output ready);
endinterface

// ===== hw/rtl/sorted_table_insert_delete_search.sv =====
// Sorted key table: keeps up to DEPTH keys in ascending unsigned order in a row of
// compare-and-shift cells. For insert, delete and search alike, the request is
// accepted, every cell compares and shifts in parallel in that cycle, and the response is
// registered, so it appears in the cycle after acceptance. One item is taken per cycle
// whenever the response register is empty or being drained; the rate is set by the cell
// row finishing each item in its accepting cycle and the one-entry response register. No
// clearing pass after reset: only entries below the count are ever read.
// Depends on stsi_pkg, stsi_req_if, stsi_rsp_if and stsi_cell.
module sorted_table_insert_delete_search #(
    parameter int DEPTH     = stsi_pkg::DEPTH_DEFAULT,
    parameter int KEY_WIDTH = stsi_pkg::KEY_WIDTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    stsi_req_if.sink    req,
    stsi_rsp_if.source  rsp
);

    localparam int HeldW = $clog2(DEPTH + 1);
    localparam int IdxW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [HeldW-1:0]              held_reg;
    logic [HeldW-1:0]              held_next;
    logic                          rsp_valid_reg;
    logic [stsi_pkg::STATUS_W-1:0] status_reg;
    logic [stsi_pkg::INDEX_W-1:0]  index_reg;
    logic [stsi_pkg::COUNT_W-1:0]  count_reg;

    logic                          accept;
    logic                          full;
    logic                          bad_pos;
    stsi_pkg::cell_ctrl_t          ctrl;
    logic [KEY_WIDTH-1:0]          key_m;

    stsi_pkg::link_t               link  [DEPTH];
    logic [KEY_WIDTH-1:0]          key_q [DEPTH];
    logic [DEPTH-1:0]              place;
    logic [DEPTH-1:0]              first;

    logic [IdxW-1:0]               ins_idx;
    logic [IdxW-1:0]               found_idx;
    logic                          found;
    stsi_pkg::status_t             status_d;
    logic [IdxW-1:0]               index_d;

    assign accept  = req.valid && req.ready;
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign full    = 32'(held_reg) >= 32'(DEPTH);
    assign bad_pos = 32'(req.position) >= 32'(held_reg);
    assign key_m   = KEY_WIDTH'(req.key);

    assign ctrl.ins = accept && (req.req_type == stsi_pkg::REQ_INSERT) && !full;
    assign ctrl.del = accept && (req.req_type == stsi_pkg::REQ_DELETE) && !bad_pos;

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        stsi_pkg::link_t      left_link;
        logic [KEY_WIDTH-1:0] left_key;
        logic [KEY_WIDTH-1:0] right_key;

        if (g == 0)
        begin : g_first
            assign left_link = '0;
            assign left_key  = '0;
        end
        else
        begin : g_mid
            assign left_link = link[g-1];
            assign left_key  = key_q[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_last
            assign right_key = '0;
        end
        else
        begin : g_up
            assign right_key = key_q[g+1];
        end

        stsi_cell #(
            .DEPTH     (DEPTH),
            .KEY_WIDTH (KEY_WIDTH),
            .CELL_IDX  (g)
        ) u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .key       (key_m),
            .held      (held_reg),
            .position  (req.position),
            .left_link (left_link),
            .left_key  (left_key),
            .right_key (right_key),
            .link      (link[g]),
            .key_q     (key_q[g]),
            .place     (place[g]),
            .first     (first[g])
        );
    end

    // one-hot to binary
    always_comb
    begin
        ins_idx   = '0;
        found_idx = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (place[i])
                ins_idx = ins_idx | IdxW'(i);
            if (first[i])
                found_idx = found_idx | IdxW'(i);
        end
    end

    assign found = |first;

    always_comb
    begin
        held_next = held_reg;
        if (ctrl.ins)
            held_next = held_reg + HeldW'(1);
        else if (ctrl.del)
            held_next = held_reg - HeldW'(1);
    end

    always_comb
    begin
        status_d = stsi_pkg::ST_OK;
        index_d  = '0;
        unique case (req.req_type)
            stsi_pkg::REQ_INSERT:
            begin
                if (full)
                    status_d = stsi_pkg::ST_FULL;
                else
                    index_d = ins_idx;
            end
            stsi_pkg::REQ_DELETE:
            begin
                if (bad_pos)
                    status_d = stsi_pkg::ST_BADPOS;
                index_d = IdxW'(req.position);
            end
            stsi_pkg::REQ_SEARCH:
            begin
                if (found)
                    index_d = found_idx;
                else
                    status_d = stsi_pkg::ST_NOTFOUND;
            end
            default:
            begin
                status_d = stsi_pkg::ST_OK;
                index_d  = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            held_reg <= held_next;
            if (accept)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // delete echoes the raw position, which has the same width as the index
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_d;
            if (req.req_type == stsi_pkg::REQ_DELETE)
                index_reg <= req.position;
            else
                index_reg <= stsi_pkg::INDEX_W'(index_d);
            count_reg  <= stsi_pkg::COUNT_W'(held_next);
        end
    end

    assign rsp.valid  = rsp_valid_reg;
    assign rsp.status = status_reg;
    assign rsp.index  = index_reg;
    assign rsp.count  = count_reg;

    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(held_reg) <= 32'(DEPTH))
        else $error("key count beyond table depth");

    a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.ins |=> held_reg == $past(held_reg) + HeldW'(1))
        else $error("insert did not grow the count");

    a_ins_place: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.ins |-> $onehot(place))
        else $error("insert slot not unique");

    a_first_match: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(first))
        else $error("several lowest matches");

    a_rsp_follow: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp_valid_reg)
        else $error("accepted item without response");

endmodule

// ===== hw/rtl/stsi_cell.sv =====
// One compare-and-shift cell of the sorted key table: holds one key.
// Depends on stsi_pkg (cell_ctrl_t, link_t).
module stsi_cell #(
    parameter int DEPTH     = stsi_pkg::DEPTH_DEFAULT,
    parameter int KEY_WIDTH = stsi_pkg::KEY_WIDTH_DEFAULT,
    parameter int CELL_IDX  = 0,
    localparam int HeldW    = $clog2(DEPTH + 1)
) (
    input  logic                        clk,
    input  stsi_pkg::cell_ctrl_t        ctrl,
    input  logic [KEY_WIDTH-1:0]        key,
    input  logic [HeldW-1:0]            held,
    input  logic [stsi_pkg::POS_W-1:0]  position,
    input  stsi_pkg::link_t             left_link,
    input  logic [KEY_WIDTH-1:0]        left_key,
    input  logic [KEY_WIDTH-1:0]        right_key,
    output stsi_pkg::link_t             link,
    output logic [KEY_WIDTH-1:0]        key_q,
    output logic                        place,
    output logic                        first
);

    logic [KEY_WIDTH-1:0] key_reg;
    logic [KEY_WIDTH-1:0] key_next;
    logic                 occupied;
    logic                 at_end;
    logic                 in_gap;

    assign occupied = 32'(CELL_IDX) < 32'(held);
    assign at_end   = 32'(CELL_IDX) == 32'(held);
    assign in_gap   = (32'(CELL_IDX) >= 32'(position)) && (32'(CELL_IDX + 1) < 32'(held));

    assign link.gt = occupied && (key_reg > key);
    assign link.eq = occupied && (key_reg == key);
    assign place   = !left_link.gt && (link.gt || at_end);
    assign first   = link.eq && !left_link.eq;
    assign key_q   = key_reg;

    always_comb
    begin
        key_next = key_reg;
        if (ctrl.ins)
        begin
            if (left_link.gt)
                key_next = left_key;
            else if (place)
                key_next = key;
        end
        else if (ctrl.del && in_gap)
        begin
            key_next = right_key;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule
